>>> sv/smcsl_pkg.sv
// shared types, constants and helper functions of the staggered slew limiter
`timescale 1ns / 1ps
package smcsl_pkg;

  localparam int ANGLE_W   = 12;
  localparam int DELAY_W   = 13;
  localparam int ELAPSED_W = 16;
  localparam int STEP_W    = 13;
  localparam int SPEED_W   = 16;
  localparam int TICK_W    = 12;
  localparam int GAP_W     = 10;
  localparam int PCOUNT_W  = 4;
  localparam int CMD_W     = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DEG_W     = 8;
  localparam int IDX_W     = 3;
  localparam int PROD_W    = SPEED_W + TICK_W;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_PETAL_COUNT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOOM_ANGLE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CLOSE_ANGLE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SLEW_SPEED  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_STAGGER_GAP = 3'd4;

  // register reset values
  localparam logic [PCOUNT_W-1:0] RST_PETAL_COUNT = 4'd8;
  localparam logic [ANGLE_W-1:0]  RST_BLOOM_ANGLE = 12'd1280;
  localparam logic [ANGLE_W-1:0]  RST_CLOSE_ANGLE = 12'd80;
  localparam logic [SPEED_W-1:0]  RST_SLEW_SPEED  = 16'd240;
  localparam logic [GAP_W-1:0]    RST_STAGGER_GAP = 10'd200;

  // request kinds and command codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CMD  = 1'b1;
  localparam logic [CMD_W-1:0] CMD_OPEN    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STAG_LR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STAG_OI = 2'd3;

  localparam logic [DELAY_W-1:0]   DELAY_MAX   = 13'h1FFF;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [ANGLE_W-1:0]   HALF_DEG    = 12'd8;

  // step = floor(prod / 1000) via reciprocal; any step above 4095 lands on target
  localparam logic [STEP_W-1:0] STEP_SAT      = 13'd4096;
  localparam logic [PROD_W-1:0] STEP_SAT_PROD = 28'd4096000;
  localparam int               RECIP_IN_W    = 22;
  localparam int               RECIP_M_W     = 23;
  localparam int               RECIP_SHIFT   = 32;
  localparam logic [RECIP_M_W-1:0] RECIP_M   = 23'd4294968;

  typedef struct packed {
    logic [ANGLE_W-1:0] cur;
    logic [ANGLE_W-1:0] tgt;
    logic [DELAY_W-1:0] dly;
  } petal_t;

  typedef struct packed {
    logic                 is_cmd;
    logic [CMD_W-1:0]     cmd;
    logic [STEP_W-1:0]    step;
    logic                 running;
    logic [ELAPSED_W-1:0] elapsed;
    logic [ANGLE_W-1:0]   bloom;
    logic [ANGLE_W-1:0]   close;
    logic [GAP_W-1:0]     gap;
  } upd_ctrl_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_step;
  } step_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_UPD,
    ST_RPT
  } state_t;

  // absolute distance between target and current angle
  function automatic logic [ANGLE_W-1:0] angle_dist(input petal_t p);
    angle_dist = (p.tgt > p.cur) ? (p.tgt - p.cur) : (p.cur - p.tgt);
  endfunction

  // more than half a degree away from target
  function automatic logic petal_far(input petal_t p);
    petal_far = angle_dist(p) > HALF_DEG;
  endfunction

  // round to whole degrees, saturating at the field maximum
  function automatic logic [DEG_W-1:0] round_deg(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W:0]   sum;
    logic [ANGLE_W-4:0] deg;
    sum = {1'b0, a} + {1'b0, HALF_DEG};
    deg = sum[ANGLE_W:4];
    round_deg = (deg > 9'd255) ? 8'd255 : deg[DEG_W-1:0];
  endfunction

endpackage

>>> sv/smcsl_cell.sv
// one storage cell of the petal ring, shifts its contents toward the head
`timescale 1ns / 1ps
module smcsl_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  smcsl_pkg::petal_t     d_in,
  output smcsl_pkg::petal_t     d_out
);

  smcsl_pkg::petal_t petal_r;

  // petal state, reset to the closed angle with no delay
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      petal_r.cur <= smcsl_pkg::RST_CLOSE_ANGLE;
      petal_r.tgt <= smcsl_pkg::RST_CLOSE_ANGLE;
      petal_r.dly <= '0;
    end else if (shift_en) begin
      petal_r <= d_in;
    end
  end

  assign d_out = petal_r;

endmodule

>>> sv/smcsl_step.sv
// slew step per tick: speed * ms, then division by 1000 through a reciprocal
`timescale 1ns / 1ps
module smcsl_step (
  input  logic                                clk,
  input  smcsl_pkg::step_ctrl_t               ctrl,
  input  logic [smcsl_pkg::SPEED_W-1:0]       speed,
  input  logic [smcsl_pkg::TICK_W-1:0]        tick_ms,
  output logic [smcsl_pkg::STEP_W-1:0]        step
);

  localparam int RW = smcsl_pkg::RECIP_IN_W + smcsl_pkg::RECIP_M_W;

  logic [smcsl_pkg::PROD_W-1:0] prod_r;
  logic [smcsl_pkg::STEP_W-1:0] step_r;
  logic [smcsl_pkg::STEP_W-1:0] step_nxt;
  logic [RW-1:0]                recip;

  // first stage: speed times milliseconds
  always_ff @(posedge clk) begin
    if (ctrl.ld_prod) begin
      prod_r <= smcsl_pkg::PROD_W'(speed) * smcsl_pkg::PROD_W'(tick_ms);
    end
  end

  // second stage: exact divide by 1000 below the saturation point
  always_comb begin
    recip = RW'(prod_r[smcsl_pkg::RECIP_IN_W-1:0]) * RW'(smcsl_pkg::RECIP_M);
    if (prod_r >= smcsl_pkg::STEP_SAT_PROD) begin
      step_nxt = smcsl_pkg::STEP_SAT;
    end else begin
      step_nxt = recip[RW-1:smcsl_pkg::RECIP_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_step) begin
      step_r <= step_nxt;
    end
  end

  assign step = step_r;

endmodule

>>> sv/smcsl_update.sv
// head-of-ring update of one petal for a command or a tick
`timescale 1ns / 1ps
module smcsl_update #(
  parameter int NW = 4
) (
  input  smcsl_pkg::upd_ctrl_t  ctrl,
  input  logic [NW-1:0]         pos,
  input  logic [NW-1:0]         n_act,
  input  smcsl_pkg::petal_t     p_in,
  output smcsl_pkg::petal_t     p_out,
  output logic                  far
);

  localparam int DPW = (NW + smcsl_pkg::GAP_W > smcsl_pkg::DELAY_W) ?
                       NW + smcsl_pkg::GAP_W : smcsl_pkg::DELAY_W;

  logic                         active;
  logic [NW-1:0]                mirror;
  logic [NW-1:0]                slots;
  logic [DPW-1:0]               dly_full;
  logic [smcsl_pkg::DELAY_W-1:0] dly_new;
  logic [smcsl_pkg::ANGLE_W-1:0] gap_abs;
  logic                         held;

  // start delay for a staggered sequence
  always_comb begin
    mirror = n_act - NW'(1) - pos;
    slots  = pos;
    if (ctrl.cmd == smcsl_pkg::CMD_STAG_OI && mirror < pos) begin
      slots = mirror;
    end
    dly_full = DPW'(slots) * DPW'(ctrl.gap);
    if (dly_full > DPW'(smcsl_pkg::DELAY_MAX)) begin
      dly_new = smcsl_pkg::DELAY_MAX;
    end else begin
      dly_new = dly_full[smcsl_pkg::DELAY_W-1:0];
    end
  end

  // new petal state
  always_comb begin
    active  = pos < n_act;
    gap_abs = smcsl_pkg::angle_dist(p_in);
    held    = ctrl.running && (smcsl_pkg::DELAY_W'(ctrl.elapsed) < p_in.dly) &&
              (ctrl.elapsed < smcsl_pkg::ELAPSED_W'(p_in.dly));
    p_out   = p_in;
    if (active) begin
      if (ctrl.is_cmd) begin
        case (ctrl.cmd)
          smcsl_pkg::CMD_OPEN: begin
            p_out.tgt = ctrl.bloom;
            p_out.dly = '0;
          end
          smcsl_pkg::CMD_CLOSE: begin
            p_out.tgt = ctrl.close;
            p_out.dly = '0;
          end
          default: begin
            p_out.tgt = ctrl.bloom;
            p_out.dly = dly_new;
          end
        endcase
      end else if (!held) begin
        if (smcsl_pkg::STEP_W'(gap_abs) <= ctrl.step) begin
          p_out.cur = p_in.tgt;
        end else if (p_in.tgt > p_in.cur) begin
          p_out.cur = p_in.cur + ctrl.step[smcsl_pkg::ANGLE_W-1:0];
        end else begin
          p_out.cur = p_in.cur - ctrl.step[smcsl_pkg::ANGLE_W-1:0];
        end
      end
    end
    far = active && smcsl_pkg::petal_far(p_out);
  end

endmodule

>>> sv/staggered_multi_channel_slew_limiter_top.sv
// top level of the staggered multi-channel slew limiter
`timescale 1ns / 1ps
// Usage:
// The input stream carries one request per transfer: in_tuser is the request
// kind (tick or command), in_tdata holds the command code and the tick length
// in milliseconds. For each accepted request the block updates the active
// petals and then sends one result per active petal on the output stream,
// lowest petal first, with out_tlast on the last active petal.
// Petal state lives in a ring of PETAL_COUNT_MAX cells that, during a rotation,
// moves one cell per cycle past a single update unit at the head, unless the receiver stalls.
// Sequence: the step multiply, then the reciprocal divide, then the update
// rotation over every ring cell, then the report rotation over every ring cell,
// then idle, where the next request is taken; a new request is not accepted
// until the report rotation of the one before it is done.
// The last result may still wait in the output register.
// When the receiver stalls, the report rotation pauses with the result held.
// Reset (synchronous, rst_n low) restores register defaults, puts every petal
// at the closed angle with no delay and stops any sequence.
// Configuration writes are taken at any clock with cfg_we high.
module staggered_multi_channel_slew_limiter_top #(
  parameter int PETAL_COUNT_MAX = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // command [1:0], tick_ms [13:2], zero [15:14]
  input  logic        in_tuser,   // req_type [0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // petal_index [2:0], petal_angle [10:3],
                                  // petal_moving [11], flower_moving [12], zero [15:13]
  output logic        out_tlast,  // last [0]
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int NW = $clog2(PETAL_COUNT_MAX + 1);
  localparam logic [NW-1:0] POS_LAST = NW'(PETAL_COUNT_MAX - 1);

  // configuration registers
  logic [smcsl_pkg::PCOUNT_W-1:0] petal_count_r;
  logic [smcsl_pkg::ANGLE_W-1:0]  bloom_angle_r;
  logic [smcsl_pkg::ANGLE_W-1:0]  close_angle_r;
  logic [smcsl_pkg::SPEED_W-1:0]  slew_speed_r;
  logic [smcsl_pkg::GAP_W-1:0]    stagger_gap_r;

  // request and sequence state
  smcsl_pkg::state_t               state_r, state_nxt;
  logic                            req_type_r;
  logic [smcsl_pkg::CMD_W-1:0]     cmd_r;
  logic [smcsl_pkg::TICK_W-1:0]    tick_r;
  logic                            running_r;
  logic [smcsl_pkg::ELAPSED_W-1:0] elapsed_r;
  logic [NW-1:0]                   pos_r, pos_nxt;
  logic                            any_r;
  logic [NW-1:0]                   n_act;
  logic [smcsl_pkg::STEP_W-1:0]    step;
  logic [smcsl_pkg::ELAPSED_W:0]   elapsed_sum;

  // control decoded from the state
  logic                            shift_en;
  logic                            emit;
  smcsl_pkg::step_ctrl_t           step_ctrl;
  smcsl_pkg::upd_ctrl_t            upd_ctrl;
  logic                            slot_free;

  // ring
  smcsl_pkg::petal_t               ring_q [PETAL_COUNT_MAX];
  smcsl_pkg::petal_t               ring_d [PETAL_COUNT_MAX];
  smcsl_pkg::petal_t               upd_out;
  logic                            upd_far;

  // output register
  logic                            out_valid_r;
  logic [smcsl_pkg::IDX_W-1:0]     out_idx_r;
  logic [smcsl_pkg::DEG_W-1:0]     out_deg_r;
  logic                            out_pmov_r;
  logic                            out_fmov_r;
  logic                            out_last_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      petal_count_r <= smcsl_pkg::RST_PETAL_COUNT;
      bloom_angle_r <= smcsl_pkg::RST_BLOOM_ANGLE;
      close_angle_r <= smcsl_pkg::RST_CLOSE_ANGLE;
      slew_speed_r  <= smcsl_pkg::RST_SLEW_SPEED;
      stagger_gap_r <= smcsl_pkg::RST_STAGGER_GAP;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        smcsl_pkg::REG_PETAL_COUNT: petal_count_r <= cfg_wdata[smcsl_pkg::PCOUNT_W-1:0];
        smcsl_pkg::REG_BLOOM_ANGLE: bloom_angle_r <= cfg_wdata[smcsl_pkg::ANGLE_W-1:0];
        smcsl_pkg::REG_CLOSE_ANGLE: close_angle_r <= cfg_wdata[smcsl_pkg::ANGLE_W-1:0];
        smcsl_pkg::REG_SLEW_SPEED:  slew_speed_r  <= cfg_wdata[smcsl_pkg::SPEED_W-1:0];
        smcsl_pkg::REG_STAGGER_GAP: stagger_gap_r <= cfg_wdata[smcsl_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // active petal count, clamped to the ring size, with zero taken as one
  always_comb begin
    if (petal_count_r == '0) begin
      n_act = NW'(1);
    end else if (int'(petal_count_r) > PETAL_COUNT_MAX) begin
      n_act = NW'(PETAL_COUNT_MAX);
    end else begin
      n_act = NW'(petal_count_r);
    end
  end

  assign slot_free = !out_valid_r || out_tready;

  // sequencer: next state and control
  always_comb begin
    state_nxt         = state_r;
    pos_nxt           = pos_r;
    shift_en          = 1'b0;
    emit              = 1'b0;
    step_ctrl.ld_prod = 1'b0;
    step_ctrl.ld_step = 1'b0;
    in_tready         = 1'b0;
    unique case (state_r)
      smcsl_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = smcsl_pkg::ST_MUL;
        end
      end
      smcsl_pkg::ST_MUL: begin
        step_ctrl.ld_prod = 1'b1;
        state_nxt         = smcsl_pkg::ST_DIV;
      end
      smcsl_pkg::ST_DIV: begin
        step_ctrl.ld_step = 1'b1;
        state_nxt         = smcsl_pkg::ST_UPD;
      end
      smcsl_pkg::ST_UPD: begin
        shift_en = 1'b1;
        if (pos_r == POS_LAST) begin
          pos_nxt   = '0;
          state_nxt = smcsl_pkg::ST_RPT;
        end else begin
          pos_nxt = pos_r + NW'(1);
        end
      end
      smcsl_pkg::ST_RPT: begin
        if (slot_free) begin
          shift_en = 1'b1;
          emit     = pos_r < n_act;
          if (pos_r == POS_LAST) begin
            pos_nxt   = '0;
            state_nxt = smcsl_pkg::ST_IDLE;
          end else begin
            pos_nxt = pos_r + NW'(1);
          end
        end
      end
      default: begin
        state_nxt = smcsl_pkg::ST_IDLE;
        pos_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smcsl_pkg::ST_IDLE;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_type_r <= in_tuser;
      cmd_r      <= in_tdata[1:0];
      tick_r     <= in_tdata[13:2];
    end
  end

  // sequence flag and saturating elapsed counter
  assign elapsed_sum = {1'b0, elapsed_r} + (smcsl_pkg::ELAPSED_W + 1)'(tick_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      elapsed_r <= '0;
    end else if (state_r == smcsl_pkg::ST_MUL) begin
      if (req_type_r == smcsl_pkg::REQ_CMD) begin
        running_r <= (cmd_r == smcsl_pkg::CMD_STAG_LR) || (cmd_r == smcsl_pkg::CMD_STAG_OI);
        elapsed_r <= '0;
      end else if (running_r && tick_r != '0) begin
        elapsed_r <= elapsed_sum[smcsl_pkg::ELAPSED_W] ? smcsl_pkg::ELAPSED_MAX :
                     elapsed_sum[smcsl_pkg::ELAPSED_W-1:0];
      end
    end
  end

  // any-petal-moving flag gathered during the update rotation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0;
    end else if (state_r == smcsl_pkg::ST_MUL) begin
      any_r <= 1'b0;
    end else if (state_r == smcsl_pkg::ST_UPD && upd_far) begin
      any_r <= 1'b1;
    end
  end

  smcsl_step u_step (
    .clk     (clk),
    .ctrl    (step_ctrl),
    .speed   (slew_speed_r),
    .tick_ms (tick_r),
    .step    (step)
  );

  always_comb begin
    upd_ctrl.is_cmd  = req_type_r == smcsl_pkg::REQ_CMD;
    upd_ctrl.cmd     = cmd_r;
    upd_ctrl.step    = step;
    upd_ctrl.running = running_r;
    upd_ctrl.elapsed = elapsed_r;
    upd_ctrl.bloom   = bloom_angle_r;
    upd_ctrl.close   = close_angle_r;
    upd_ctrl.gap     = stagger_gap_r;
  end

  smcsl_update #(
    .NW (NW)
  ) u_update (
    .ctrl  (upd_ctrl),
    .pos   (pos_r),
    .n_act (n_act),
    .p_in  (ring_q[0]),
    .p_out (upd_out),
    .far   (upd_far)
  );

  // ring of petal cells; the tail takes the updated head or the head itself
  for (genvar k = 0; k < PETAL_COUNT_MAX; k++) begin : g_ring
    if (k == PETAL_COUNT_MAX - 1) begin : g_tail
      assign ring_d[k] = (state_r == smcsl_pkg::ST_UPD) ? upd_out : ring_q[0];
    end else begin : g_body
      assign ring_d[k] = ring_q[k+1];
    end
    smcsl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (ring_d[k]),
      .d_out    (ring_q[k])
    );
  end

  // output register, loaded from the ring head during the report rotation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_idx_r  <= smcsl_pkg::IDX_W'(pos_r);
      out_deg_r  <= smcsl_pkg::round_deg(ring_q[0].cur);
      out_pmov_r <= smcsl_pkg::petal_far(ring_q[0]);
      out_fmov_r <= any_r;
      out_last_r <= pos_r == n_act - NW'(1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_fmov_r, out_pmov_r, out_deg_r, out_idx_r};
  assign out_tlast  = out_last_r;

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == smcsl_pkg::ST_MUL))
    else $error("request transfer did not start the step calculation");

  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smcsl_pkg::ST_IDLE) |-> (pos_r == '0))
    else $error("ring position not home while idle");

  a_petal_implies_flower: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[11]) |-> out_tdata[12])
    else $error("petal moving without flower moving");

  a_emit_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (slot_free && state_r == smcsl_pkg::ST_RPT))
    else $error("result loaded over a pending result");

endmodule

>>> tb/petal_status_checker.sv
// checker that predicts the petal status stream of the slew limiter and compares it
`timescale 1ns / 1ps
module petal_status_checker
  import smcsl_pkg::*;
#(
  parameter int PETALS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // command [1:0], tick_ms [13:2], zero [15:14]
  input  logic        in_tuser,   // req_type [0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // petal_index [2:0], petal_angle [10:3],
                                  // petal_moving [11], flower_moving [12], zero [15:13]
  input  logic        out_tlast,  // last [0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          awaited
);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [DEG_W-1:0] degrees;
    logic             petal_moving;
    logic             flower_moving;
    logic             last;
  } petal_status_t;

  // status words still owed by the block, oldest first
  petal_status_t status_due[$];

  // predicted petal and sequence state
  logic [ANGLE_W-1:0]   angle_now  [PETALS];
  logic [ANGLE_W-1:0]   angle_goal [PETALS];
  logic [DELAY_W-1:0]   hold_ms    [PETALS];
  logic                 seq_run;
  logic [ELAPSED_W-1:0] seq_ms;

  // register copies
  logic [PCOUNT_W-1:0] reg_count;
  logic [ANGLE_W-1:0]  reg_bloom;
  logic [ANGLE_W-1:0]  reg_close;
  logic [SPEED_W-1:0]  reg_speed;
  logic [GAP_W-1:0]    reg_gap;

  function automatic int unsigned angle_gap(input int unsigned a, input int unsigned b);
    angle_gap = (a > b) ? a - b : b - a;
  endfunction

  // petal count register clamped to the petals that exist, with zero taken as one
  function automatic int unsigned active_petals();
    active_petals = reg_count;
    if (active_petals < 1) active_petals = 1;
    if (active_petals > PETALS) active_petals = PETALS;
  endfunction

  // apply one request to the predicted state and queue the status of every active petal
  task automatic predict_request(input logic is_cmd, input logic [CMD_W-1:0] code,
                                 input logic [TICK_W-1:0] ms);
    int unsigned n, slots, span, step, sum, cur, goal, deg;
    logic any;
    petal_status_t s;
    n = active_petals();
    if (is_cmd) begin
      seq_ms = '0;
      seq_run = (code == CMD_STAG_LR) || (code == CMD_STAG_OI);
      for (int i = 0; i < n; i++) begin
        if (!seq_run) begin
          hold_ms[i] = '0;
          angle_goal[i] = (code == CMD_OPEN) ? reg_bloom : reg_close;
        end else begin
          // outside-in mirrors the slot count around the middle petal
          slots = i;
          if (code == CMD_STAG_OI && (n - 1 - i) < slots) slots = n - 1 - i;
          span = slots * reg_gap;
          hold_ms[i] = (span > DELAY_MAX) ? DELAY_MAX : span[DELAY_W-1:0];
          angle_goal[i] = reg_bloom;
        end
      end
    end else if (ms != '0) begin
      if (seq_run) begin
        sum = seq_ms + ms;
        seq_ms = (sum > ELAPSED_MAX) ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
      end
      step = (reg_speed * ms) / 1000;
      if (step != 0) begin
        for (int i = 0; i < n; i++) begin
          // petals still waiting for their start delay hold still
          if (!(seq_run && seq_ms < hold_ms[i])) begin
            cur = angle_now[i];
            goal = angle_goal[i];
            if (angle_gap(goal, cur) <= step) cur = goal;
            else if (goal > cur) cur = cur + step;
            else cur = cur - step;
            angle_now[i] = cur[ANGLE_W-1:0];
          end
        end
      end
    end

    any = 1'b0;
    for (int i = 0; i < n; i++)
      if (angle_gap(angle_goal[i], angle_now[i]) > HALF_DEG) any = 1'b1;

    for (int i = 0; i < n; i++) begin
      cur = angle_now[i];
      deg = (cur + HALF_DEG) >> 4;
      s.index = i[IDX_W-1:0];
      s.degrees = (deg > 255) ? 8'd255 : deg[DEG_W-1:0];
      s.petal_moving = angle_gap(angle_goal[i], angle_now[i]) > HALF_DEG;
      s.flower_moving = any;
      s.last = (i == n - 1);
      status_due.push_back(s);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    petal_status_t want, got;
    if (!rst_n) begin
      // reset: registers to defaults, petals closed, no sequence
      mismatches = 0;
      reg_count = RST_PETAL_COUNT;
      reg_bloom = RST_BLOOM_ANGLE;
      reg_close = RST_CLOSE_ANGLE;
      reg_speed = RST_SLEW_SPEED;
      reg_gap = RST_STAGGER_GAP;
      for (int i = 0; i < PETALS; i++) begin
        angle_now[i] = RST_CLOSE_ANGLE;
        angle_goal[i] = RST_CLOSE_ANGLE;
        hold_ms[i] = '0;
      end
      seq_run = 1'b0;
      seq_ms = '0;
      status_due.delete();
    end else begin
      // result transfer against the oldest expectation
      if (out_tvalid && out_tready) begin
        got.index = out_tdata[2:0];
        got.degrees = out_tdata[10:3];
        got.petal_moving = out_tdata[11];
        got.flower_moving = out_tdata[12];
        got.last = out_tlast;
        if (status_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual index %0d angle %0d",
                   $time, got.index, got.degrees);
        end else begin
          want = status_due.pop_front();
          check_field("petal_index", want.index, got.index);
          check_field("petal_angle", want.degrees, got.degrees);
          check_field("petal_moving", want.petal_moving, got.petal_moving);
          check_field("flower_moving", want.flower_moving, got.flower_moving);
          check_field("last", want.last, got.last);
        end
      end
      // register writes, masked to register width
      if (cfg_we) begin
        case (cfg_addr)
          REG_PETAL_COUNT: reg_count = cfg_wdata[PCOUNT_W-1:0];
          REG_BLOOM_ANGLE: reg_bloom = cfg_wdata[ANGLE_W-1:0];
          REG_CLOSE_ANGLE: reg_close = cfg_wdata[ANGLE_W-1:0];
          REG_SLEW_SPEED:  reg_speed = cfg_wdata[SPEED_W-1:0];
          REG_STAGGER_GAP: reg_gap = cfg_wdata[GAP_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_request(in_tuser, in_tdata[1:0], in_tdata[13:2]);
    end
    awaited <= status_due.size();
  end

endmodule

>>> tb/staggered_multi_channel_slew_limiter_top_tb.sv
// testbench top: directed and random requests with idling phases for the slew limiter
`timescale 1ns / 1ps
module staggered_multi_channel_slew_limiter_top_tb;
  import smcsl_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches;
  int awaited;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  staggered_multi_channel_slew_limiter_top #(
    .PETAL_COUNT_MAX(8)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  petal_status_checker #(
    .PETALS(8)
  ) status_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .awaited(awaited)
  );

  // receiver stalls at random
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // one request transfer, with random idle cycles ahead of it
  task automatic send_request(input logic is_cmd, input logic [CMD_W-1:0] code,
                              input logic [TICK_W-1:0] ms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= is_cmd;
    in_tdata <= {2'b00, ms, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // write all five registers; bits above each register's width are random
  task automatic load_settings(input logic [PCOUNT_W-1:0] count,
                               input logic [ANGLE_W-1:0] bloom,
                               input logic [ANGLE_W-1:0] close,
                               input logic [SPEED_W-1:0] speed,
                               input logic [GAP_W-1:0] gap);
    logic [15:0] pad;
    pad = 16'($urandom);
    cfg_we <= 1'b1;
    cfg_addr <= REG_PETAL_COUNT;
    cfg_wdata <= {pad[15:4], count};
    @(posedge clk);
    cfg_addr <= REG_BLOOM_ANGLE;
    cfg_wdata <= {pad[15:12], bloom};
    @(posedge clk);
    cfg_addr <= REG_CLOSE_ANGLE;
    cfg_wdata <= {pad[11:8], close};
    @(posedge clk);
    cfg_addr <= REG_SLEW_SPEED;
    cfg_wdata <= speed;
    @(posedge clk);
    cfg_addr <= REG_STAGGER_GAP;
    cfg_wdata <= {pad[15:10], gap};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // release the input, wait until every owed status word has been seen, then settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // mostly a command followed by a run of ticks, some single noise requests
  task automatic run_flower_traffic(input int budget);
    int sent;
    int ticks;
    logic [CMD_W-1:0] code;
    logic [TICK_W-1:0] ms;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 12) begin
        send_request(1'($urandom), 2'($urandom), 12'($urandom));
        sent++;
      end else begin
        code = 2'($urandom);
        send_request(REQ_CMD, code, 12'($urandom));
        sent++;
        ticks = $urandom_range(2, 8);
        repeat (ticks) begin
          case ($urandom_range(9))
            0: ms = '0;
            1: ms = 12'($urandom);
            default: ms = 12'($urandom_range(1, 400));
          endcase
          send_request(REQ_TICK, 2'($urandom), ms);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero tick, open, full tick, tiny tick, close, staggers
    send_request(REQ_TICK, CMD_STAG_OI, 12'd0);
    send_request(REQ_CMD, CMD_OPEN, 12'hFFF);
    send_request(REQ_TICK, CMD_CLOSE, 12'hFFF);
    send_request(REQ_TICK, CMD_OPEN, 12'd1);
    send_request(REQ_CMD, CMD_CLOSE, 12'd0);
    send_request(REQ_TICK, CMD_STAG_LR, 12'd100);
    send_request(REQ_CMD, CMD_STAG_LR, 12'hAAA);
    send_request(REQ_TICK, CMD_OPEN, 12'd300);
    send_request(REQ_TICK, CMD_OPEN, 12'd250);
    send_request(REQ_TICK, CMD_OPEN, 12'd1000);
    send_request(REQ_CMD, CMD_STAG_OI, 12'h555);
    send_request(REQ_TICK, CMD_OPEN, 12'd450);
    send_request(REQ_TICK, CMD_OPEN, 12'hFFF);

    // one petal (count zero clamps up), full angle, fastest slew, widest gap
    wait_idle();
    load_settings(4'd0, 12'hFFF, 12'd0, 16'hFFFF, 10'h3FF);
    send_request(REQ_CMD, CMD_OPEN, 12'd0);
    send_request(REQ_TICK, CMD_OPEN, 12'hFFF);
    send_request(REQ_CMD, CMD_STAG_OI, 12'd0);
    send_request(REQ_CMD, CMD_CLOSE, 12'd0);
    send_request(REQ_TICK, CMD_OPEN, 12'd1);

    // count above range clamps down, zero slew and zero gap
    wait_idle();
    load_settings(4'hF, 12'd2880, 12'd0, 16'd0, 10'd0);
    send_request(REQ_CMD, CMD_STAG_LR, 12'd0);
    send_request(REQ_TICK, CMD_OPEN, 12'hFFF);
    send_request(REQ_CMD, CMD_OPEN, 12'd0);
    send_request(REQ_TICK, CMD_OPEN, 12'hFFF);

    // slowest nonzero slew with outside-in holds
    wait_idle();
    load_settings(4'd8, 12'd1280, 12'd2880, 16'd1, 10'h3FF);
    send_request(REQ_CMD, CMD_STAG_OI, 12'd0);
    send_request(REQ_TICK, CMD_OPEN, 12'd999);
    send_request(REQ_TICK, CMD_OPEN, 12'hFFF);

    // random phases: no idling, sender idle, receiver stall, both
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      if (p == 0)
        load_settings(4'd8, 12'($urandom_range(800, 2880)), 12'($urandom_range(0, 400)),
                      16'($urandom_range(100, 2000)), 10'($urandom_range(0, 300)));
      else
        load_settings(4'($urandom), 12'($urandom_range(0, 2880)),
                      12'($urandom_range(0, 2880)), 16'($urandom_range(20, 3000)),
                      10'($urandom));
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (p == 0) begin
        // long sequence that drives the elapsed counter into saturation
        send_request(REQ_CMD, CMD_STAG_LR, 12'd0);
        repeat (17) send_request(REQ_TICK, 2'($urandom), 12'hFFF);
        run_flower_traffic(54);
      end else begin
        run_flower_traffic(72);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaited == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
